// ===== sv/double_ended_queue_assert.svh =====
// ----------------------------------------------------------------------------
// Double-ended queue assertion macros
// Checks that the queue's control logic uses, sampled on clk, disabled in rst.
// ----------------------------------------------------------------------------
`ifndef DOUBLE_ENDED_QUEUE_ASSERT_SVH
`define DOUBLE_ENDED_QUEUE_ASSERT_SVH

// Condition a in one cycle implies condition b in the next.
`define DQ_ASSERT_NEXT(lbl, a, b, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) else $error(msg);

// Condition a implies condition b in the same cycle.
`define DQ_ASSERT_NOW(lbl, a, b, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) else $error(msg);

`endif

// ===== sv/dq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Double-ended queue package
// Sizes, request and status codes, and the control word shared by the cells.
// ----------------------------------------------------------------------------
package dq_pkg;

  localparam int CAPACITY = 32;
  localparam int WORD_W   = 32;
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  typedef logic signed [WORD_W-1:0] word_t;
  typedef logic [IDX_W-1:0]         idx_t;
  typedef logic [CNT_W-1:0]         cnt_t;

  typedef enum logic [2:0] {
    REQ_DISPLAY    = 3'd0,
    REQ_PUSH_FRONT = 3'd1,
    REQ_PUSH_BACK  = 3'd2,
    REQ_POP_FRONT  = 3'd3,
    REQ_POP_BACK   = 3'd4
  } req_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic {
    S_IDLE,
    S_SHOW
  } state_t;

  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_PUSH_FRONT,
    CELL_PUSH_BACK,
    CELL_POP_FRONT,
    CELL_ROTATE
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
    cnt_t     count;
  } cell_ctrl_t;

endpackage

// ===== sv/dq_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Double-ended queue cell
// Holds one queue word and takes its next word from itself, a neighbour,
// the front cell or the incoming beat, as the broadcast control asks.
// ----------------------------------------------------------------------------
module dq_cell (
  input  logic               clk,
  input  dq_pkg::cell_ctrl_t ctrl,
  input  dq_pkg::idx_t       index,
  input  dq_pkg::word_t      word_in,
  input  dq_pkg::word_t      left,
  input  dq_pkg::word_t      right,
  input  dq_pkg::word_t      head,
  output dq_pkg::word_t      data
);
  import dq_pkg::*;

  cnt_t  pos;
  logic  at_count;
  logic  at_tail;
  word_t data_next;

  assign pos      = CNT_W'(index);
  assign at_count = (pos == ctrl.count);
  assign at_tail  = ((pos + CNT_W'(1)) == ctrl.count);

  always_comb begin
    case (ctrl.op)
      CELL_PUSH_FRONT: data_next = (index == '0) ? word_in : left;
      CELL_PUSH_BACK:  data_next = at_count ? word_in : data;
      CELL_POP_FRONT:  data_next = right;
      CELL_ROTATE:     data_next = at_tail ? head : right;
      default:         data_next = data;
    endcase
  end

  always_ff @(posedge clk) begin
    data <= data_next;
  end

endmodule

// ===== sv/double_ended_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Double-ended queue
// Bounded deque of signed 32-bit words held in a row of shifting cells.
// ----------------------------------------------------------------------------
//
//  channel   handshake               payload
//  -------   ---------------------   ------------------------------
//  request   start high, busy low    req_type, value
//  result    strobe, one cycle       value_res, status, last
//
//  For pushes and pops the result beat appears in the cycle after the
//  request, and busy stays low, so a request may be issued every cycle.
//  A display of n stored words holds busy high after it is taken, while
//  the occupied cells rotate once round, one beat per word from the front
//  cell; each beat appears in the cycle after its rotation cycle.
//  Reset (rst, synchronous) empties the queue; the cell words are left as
//  they were and are never read until written. The receiver cannot stall.
//
module double_ended_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic [2:0]          req_type,
  input  logic signed [31:0]  value,
  output logic                strobe,
  output logic signed [31:0]  value_res,
  output logic [1:0]          status,
  output logic                last
);
  import dq_pkg::*;

  // Control state
  state_t state, state_next;
  cnt_t   count, count_next;
  cnt_t   remaining, remaining_next;

  // Result beat register
  logic   strobe_next;
  word_t  value_res_next;
  logic [1:0] status_next;
  logic   last_next;

  // Cell row
  word_t      cell_data [CAPACITY];
  cell_ctrl_t ctrl;
  cell_op_t   op;
  idx_t       tail_idx;
  logic       accept;
  logic       full;
  logic       empty;
  logic       pushpop_req;

  assign busy     = (state == S_SHOW);
  assign accept   = start && !busy;
  assign full     = (count == CNT_W'(CAPACITY));
  assign empty    = (count == '0);
  assign tail_idx = IDX_W'(count - CNT_W'(1));
  assign ctrl     = '{op: op, count: count};

  // Push or pop taken this cycle
  assign pushpop_req = accept &&
                       (req_type inside {REQ_PUSH_FRONT, REQ_PUSH_BACK,
                                         REQ_POP_FRONT, REQ_POP_BACK});

  // Front word sits in cell 0; words shift one cell per push front or pop front.
  genvar g;
  generate
    for (g = 0; g < CAPACITY; g++) begin : g_cell
      word_t left_w;
      word_t right_w;
      if (g == 0) begin : g_first
        assign left_w = value;
      end else begin : g_inner_l
        assign left_w = cell_data[g-1];
      end
      if (g == CAPACITY - 1) begin : g_lastc
        assign right_w = cell_data[0];
      end else begin : g_inner_r
        assign right_w = cell_data[g+1];
      end
      dq_cell u_cell (
        .clk     (clk),
        .ctrl    (ctrl),
        .index   (IDX_W'(g)),
        .word_in (value),
        .left    (left_w),
        .right   (right_w),
        .head    (cell_data[0]),
        .data    (cell_data[g])
      );
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      remaining <= '0;
      strobe    <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      remaining <= remaining_next;
      strobe    <= strobe_next;
    end
  end

  // Payload of the result beat needs no reset
  always_ff @(posedge clk) begin
    value_res <= value_res_next;
    status    <= status_next;
    last      <= last_next;
  end

  always_comb begin
    state_next     = state;
    count_next     = count;
    remaining_next = remaining;
    op             = CELL_HOLD;
    strobe_next    = 1'b0;
    value_res_next = '0;
    status_next    = ST_OK;
    last_next      = 1'b1;
    case (state)
      S_IDLE: begin
        if (accept) begin
          case (req_type)
            REQ_DISPLAY: begin
              if (empty) begin
                strobe_next = 1'b1;
                status_next = ST_EMPTY;
              end else begin
                // Hand the walk to the rotating state
                remaining_next = count;
                state_next     = S_SHOW;
              end
            end
            REQ_PUSH_FRONT, REQ_PUSH_BACK: begin
              strobe_next = 1'b1;
              if (full) begin
                status_next = ST_FULL;
              end else begin
                op = (req_type == REQ_PUSH_FRONT) ? CELL_PUSH_FRONT : CELL_PUSH_BACK;
                count_next = count + CNT_W'(1);
              end
            end
            REQ_POP_FRONT: begin
              strobe_next = 1'b1;
              if (empty) begin
                status_next = ST_EMPTY;
              end else begin
                value_res_next = cell_data[0];
                op             = CELL_POP_FRONT;
                count_next     = count - CNT_W'(1);
              end
            end
            REQ_POP_BACK: begin
              strobe_next = 1'b1;
              if (empty) begin
                status_next    = ST_EMPTY;
                value_res_next = '1;
              end else begin
                // Drop the tail word; the cell row keeps its data
                value_res_next = cell_data[tail_idx];
                count_next     = count - CNT_W'(1);
              end
            end
            default: begin
              // Unknown kinds give no beat
            end
          endcase
        end
      end
      S_SHOW: begin
        // Emit the front word, then rotate the occupied cells by one
        strobe_next    = 1'b1;
        value_res_next = cell_data[0];
        last_next      = (remaining == CNT_W'(1));
        op             = CELL_ROTATE;
        remaining_next = remaining - CNT_W'(1);
        if (remaining == CNT_W'(1)) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

`include "double_ended_queue_assert.svh"

  `DQ_ASSERT_NEXT(a_pushpop_beat, pushpop_req, strobe && last, "push or pop gave no final beat")
  `DQ_ASSERT_NOW(a_show_busy, strobe && !last, busy, "display beat while not busy")
  `DQ_ASSERT_NOW(a_count_bound, 1'b1, count <= CNT_W'(CAPACITY), "count above capacity")
  `DQ_ASSERT_NOW(a_full_count, strobe && (status == ST_FULL), full, "full status, not full")

endmodule
